### src/ntfs_rld_pkg.sv
// Package for the NTFS run list decoder: item structs, status codes,
// decoder phase encoding and the field size limit. No dependencies.
package ntfs_rld_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 8;

    typedef enum logic [1:0] {
        ST_RUN    = 2'd0,
        ST_SPARSE = 2'd1,
        ST_END    = 2'd2,
        ST_BAD    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_LENGTH = 3'b010,
        PH_OFFSET = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       list_start;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [63:0] run_length;
        logic [63:0] start_cluster;
    } t_out_item;

endpackage

### src/ntfs_rld_in_reg.sv
// Input register of the run list decoder.
// Depends on ntfs_rld_pkg for the input item type.
module ntfs_rld_in_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  ntfs_rld_pkg::t_in_item i_item,
    input  logic                   i_advance,
    output logic                   o_valid,
    output ntfs_rld_pkg::t_in_item o_item
);

    logic                   r_valid;
    logic                   n_valid;
    ntfs_rld_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

### src/ntfs_rld_decode.sv
// Run list decoder state and per-byte update: header parsing, field
// gathering, offset sign extension and the base cluster add. Uses ntfs_rld_pkg.
module ntfs_rld_decode #(
    parameter int unsigned MAX_FIELD_BYTES = ntfs_rld_pkg::MAX_FIELD_BYTES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  ntfs_rld_pkg::t_in_item  i_item,
    output logic                    o_res_valid,
    output ntfs_rld_pkg::t_out_item o_res
);

    ntfs_rld_pkg::t_phase r_phase, n_phase, phase_eff;
    logic [3:0]  r_len_left, n_len_left;
    logic [3:0]  r_off_left, n_off_left;
    logic [3:0]  r_off_width, n_off_width;
    logic [2:0]  r_pos, n_pos;
    logic [63:0] r_len_acc, n_len_acc;
    logic [63:0] r_off_acc, n_off_acc;
    logic [63:0] r_base, n_base;
    logic [63:0] base_eff;
    logic [63:0] len_ins;
    logic [63:0] off_ins;
    logic [63:0] off_ext;
    logic [2:0]  sign_byte;
    logic        off_sign;
    logic [3:0]  nib_len;
    logic [3:0]  nib_off;

    assign nib_len   = i_item.data_byte[3:0];
    assign nib_off   = i_item.data_byte[7:4];
    assign phase_eff = i_item.list_start ? ntfs_rld_pkg::PH_HEADER : r_phase;
    assign base_eff  = i_item.list_start ? 64'd0 : r_base;

    // Insert the incoming byte at the current byte lane of each accumulator.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            len_ins[8*k +: 8] = r_len_acc[8*k +: 8];
            off_ins[8*k +: 8] = r_off_acc[8*k +: 8];
            if (r_pos == 3'(k)) begin
                len_ins[8*k +: 8] = r_len_acc[8*k +: 8] | i_item.data_byte;
                off_ins[8*k +: 8] = r_off_acc[8*k +: 8] | i_item.data_byte;
            end
        end
    end

    // Sign extension of the offset from its own byte width.
    assign sign_byte = 3'(r_off_width - 4'd1);
    assign off_sign  = off_ins[{sign_byte, 3'b111}];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (4'(k) >= r_off_width) begin
                off_ext[8*k +: 8] = {8{off_sign}};
            end else begin
                off_ext[8*k +: 8] = off_ins[8*k +: 8];
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_len_left  = r_len_left;
        n_off_left  = r_off_left;
        n_off_width = r_off_width;
        n_pos       = r_pos;
        n_len_acc   = r_len_acc;
        n_off_acc   = r_off_acc;
        n_base      = r_base;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_fire) begin
            n_base = base_eff;
            unique case (phase_eff)
                ntfs_rld_pkg::PH_LENGTH: begin
                    n_len_acc  = len_ins;
                    n_pos      = r_pos + 3'd1;
                    n_len_left = r_len_left - 4'd1;
                    if (r_len_left == 4'd1) begin
                        n_pos = 3'd0;
                        if (r_off_width == 4'd0) begin
                            n_phase          = ntfs_rld_pkg::PH_HEADER;
                            o_res_valid      = 1'b1;
                            o_res.status     = ntfs_rld_pkg::ST_SPARSE;
                            o_res.run_length = len_ins;
                        end else begin
                            n_phase = ntfs_rld_pkg::PH_OFFSET;
                        end
                    end
                end
                ntfs_rld_pkg::PH_OFFSET: begin
                    n_off_acc  = off_ins;
                    n_pos      = r_pos + 3'd1;
                    n_off_left = r_off_left - 4'd1;
                    if (r_off_left == 4'd1) begin
                        n_base              = base_eff + off_ext;
                        n_phase             = ntfs_rld_pkg::PH_HEADER;
                        n_pos               = 3'd0;
                        o_res_valid         = 1'b1;
                        o_res.status        = ntfs_rld_pkg::ST_RUN;
                        o_res.run_length    = r_len_acc;
                        o_res.start_cluster = base_eff + off_ext;
                    end
                end
                default: begin
                    n_phase = ntfs_rld_pkg::PH_HEADER;
                    if (i_item.data_byte == 8'd0) begin
                        n_base       = 64'd0;
                        o_res_valid  = 1'b1;
                        o_res.status = ntfs_rld_pkg::ST_END;
                    end else if (nib_len == 4'd0
                            || nib_len > 4'(MAX_FIELD_BYTES)
                            || nib_off > 4'(MAX_FIELD_BYTES)) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ntfs_rld_pkg::ST_BAD;
                    end else begin
                        n_len_left  = nib_len;
                        n_off_left  = nib_off;
                        n_off_width = nib_off;
                        n_pos       = 3'd0;
                        n_len_acc   = 64'd0;
                        n_off_acc   = 64'd0;
                        n_phase     = ntfs_rld_pkg::PH_LENGTH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ntfs_rld_pkg::PH_HEADER;
            r_len_left  <= 4'd0;
            r_off_left  <= 4'd0;
            r_off_width <= 4'd0;
            r_pos       <= 3'd0;
            r_base      <= 64'd0;
        end else begin
            r_phase     <= n_phase;
            r_len_left  <= n_len_left;
            r_off_left  <= n_off_left;
            r_off_width <= n_off_width;
            r_pos       <= n_pos;
            r_base      <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_acc <= n_len_acc;
        r_off_acc <= n_off_acc;
    end

endmodule

### src/ntfs_rld_out_reg.sv
// Result register of the run list decoder.
// Depends on ntfs_rld_pkg for the result item type.
module ntfs_rld_out_reg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  ntfs_rld_pkg::t_out_item i_res,
    output logic                    o_free,
    output logic                    o_valid,
    input  logic                    i_ready,
    output ntfs_rld_pkg::t_out_item o_item
);

    logic                    r_valid;
    logic                    n_valid;
    ntfs_rld_pkg::t_out_item r_item;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_res;
        end
    end

endmodule

### src/ntfs_run_list_decoder_core.sv
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_ready  | i_item (data_byte, list_start)
// result   | out       | o_valid / i_ready  | o_item (status, run_length, start_cluster)
//
// One byte is accepted per cycle unless a result stalls; any result is registered.
// The per-byte work is one 64-bit add between the input and result registers.
// Reset clears the decoder to expect a header with a zero base cluster.
// A stalled result holds the pipeline; no item is lost or duplicated.
// Top level of the run list decoder. Depends on ntfs_rld_pkg and the
// ntfs_rld_in_reg, ntfs_rld_decode and ntfs_rld_out_reg modules.
module ntfs_run_list_decoder_core #(
    parameter int unsigned MAX_FIELD_BYTES = ntfs_rld_pkg::MAX_FIELD_BYTES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  ntfs_rld_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output ntfs_rld_pkg::t_out_item o_item
);

    logic                    in_valid;
    ntfs_rld_pkg::t_in_item  in_item;
    logic                    out_free;
    logic                    advance;
    logic                    res_valid;
    ntfs_rld_pkg::t_out_item res;

    assign advance = in_valid && out_free;

    ntfs_rld_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    ntfs_rld_decode #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ntfs_rld_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule
